@@ sv/idf_pkg.sv @@
// Shared types, constants and helpers for the include directive finder.
// No dependencies; every other file depends on this package.
package idf_pkg;

   // counter width and width of the reported offset fields
   localparam int OFFSET_BITS = 20;
   localparam int FIELD_W     = 20;
   localparam int KW_LEN      = 7;
   localparam int KW_IDX_W    = $clog2(KW_LEN + 1);
   localparam int KW_POS_W    = $clog2(KW_LEN);

   localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // the keyword "include", first letter at index 0
   localparam logic [7:0] KW_BYTES [KW_LEN] = '{8'h69, 8'h6E, 8'h63, 8'h6C, 8'h75, 8'h64, 8'h65};

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_ZERO,
      CLS_CR,
      CLS_LF,
      CLS_BLANK,
      CLS_HASH,
      CLS_QUOTE,
      CLS_LETTER
   } byte_class_type;

   typedef enum logic [2:0] {
      PH_LINE_BLANKS,
      PH_HASH_BLANKS,
      PH_KEYWORD,
      PH_AFTER_WORD,
      PH_QUOTE_BLANKS,
      PH_NAME,
      PH_TAIL,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      BRK_NONE,
      BRK_CR,
      BRK_LF
   } break_type;

   // one classified byte as it travels from front to back
   typedef struct packed {
      byte_class_type          cls;
      logic [KW_POS_W-1:0]     kw_pos;
   } entry_type;

   // fit a counter value into a result field (zero-extend or truncate)
   function automatic logic [FIELD_W-1:0] to_field(input logic [OFFSET_BITS-1:0] v);
      logic [FIELD_W+OFFSET_BITS-1:0] ext;
      ext = {{FIELD_W{1'b0}}, v};
      return ext[FIELD_W-1:0];
   endfunction

endpackage

@@ sv/idf_if.sv @@
// Handshake channels of the include directive finder: byte requests and result records.
// Depends on idf_pkg for the field width.
interface idf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source(output valid, output text_byte, input ready);
   modport sink(input valid, input text_byte, output ready);
endinterface

interface idf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic                        done_res;
   logic                        overflow;
   logic [idf_pkg::FIELD_W-1:0] line_start;
   logic [idf_pkg::FIELD_W-1:0] line_end;
   logic [idf_pkg::FIELD_W-1:0] name_start;
   logic [idf_pkg::FIELD_W-1:0] name_length;
   logic [idf_pkg::FIELD_W-1:0] following_line;

   modport source(output valid, input ready, output found, output done_res, output overflow,
                  output line_start, output line_end, output name_start, output name_length,
                  output following_line);
   modport sink(input valid, output ready, input found, input done_res, input overflow,
                input line_start, input line_end, input name_start, input name_length,
                input following_line);
endinterface

@@ sv/idf_front.sv @@
// Front end: accepts text bytes and classifies each one for the scanner.
// Depends on idf_pkg and idf_req_if.
module idf_front (
   idf_req_if.sink              req_chan,
   input  logic                 q_full,
   output logic                 push,
   output idf_pkg::entry_type   push_entry
);
   import idf_pkg::*;

   // take a beat whenever the queue has room
   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   // classify the byte and locate it within the keyword
   always_comb begin
      push_entry.cls    = CLS_OTHER;
      push_entry.kw_pos = '0;
      for (int i = 0; i < KW_LEN; i++) begin
         if (req_chan.text_byte == KW_BYTES[i]) begin
            push_entry.cls    = CLS_LETTER;
            push_entry.kw_pos = KW_POS_W'(i);
         end
      end
      if (req_chan.text_byte == CHAR_NUL) begin
         push_entry.cls = CLS_ZERO;
      end else if (req_chan.text_byte == CHAR_CR) begin
         push_entry.cls = CLS_CR;
      end else if (req_chan.text_byte == CHAR_LF) begin
         push_entry.cls = CLS_LF;
      end else if (req_chan.text_byte == CHAR_SPACE || req_chan.text_byte == CHAR_TAB) begin
         push_entry.cls = CLS_BLANK;
      end else if (req_chan.text_byte == CHAR_HASH) begin
         push_entry.cls = CLS_HASH;
      end else if (req_chan.text_byte == CHAR_QUOTE) begin
         push_entry.cls = CLS_QUOTE;
      end
   end

endmodule

@@ sv/idf_queue.sv @@
// Two-entry queue of classified bytes between front and back.
// Depends on idf_pkg.
module idf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  idf_pkg::entry_type   push_entry,
   input  logic                 pop,
   output idf_pkg::entry_type   head_entry,
   output logic                 not_empty,
   output logic                 full
);
   import idf_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head_entry = slot_ff[rd_ptr_ff];
   assign not_empty  = (count_ff != 2'd0);
   assign full       = (count_ff == 2'd2);

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ sv/idf_back.sv @@
// Back end: line scanner state machine, saturating counters and the result register.
// Depends on idf_pkg and idf_rsp_if.
module idf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  idf_pkg::entry_type   head_entry,
   input  logic                 not_empty,
   output logic                 pop,
   idf_rsp_if.source            rsp_chan
);
   import idf_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [KW_IDX_W-1:0]     kw_idx_ff, kw_idx_in;
   logic [OFFSET_BITS-1:0]  offset_ff, offset_in;
   logic [OFFSET_BITS-1:0]  line_num_ff, line_num_in;
   logic [OFFSET_BITS-1:0]  line_start_ff, line_start_in;
   logic [OFFSET_BITS-1:0]  qstart_ff, qstart_in;
   logic [OFFSET_BITS-1:0]  qlen_ff, qlen_in;
   break_type               brk_ff, brk_in;
   logic                    sat_ff, sat_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, done_ff, ovf_ff;
   logic [FIELD_W-1:0]      ls_out_ff, le_out_ff, ns_out_ff, nl_out_ff, next_out_ff;

   logic                    emit;
   logic                    rec_found, rec_done, rec_ovf;
   logic [FIELD_W-1:0]      rec_ls, rec_le, rec_ns, rec_nl, rec_next;

   byte_class_type          cls;
   logic                    is_break, pair;
   logic                    pos_max, ln_max, ql_max;
   logic [OFFSET_BITS-1:0]  pos_inc, ln_inc, ql_inc;

   // take an entry unless it would emit while a record still waits
   assign pop = not_empty && (!emit || !rsp_valid_ff || rsp_chan.ready);

   assign cls      = head_entry.cls;
   assign is_break = (cls == CLS_CR) || (cls == CLS_LF);
   assign pair     = ((brk_ff == BRK_CR) && (cls == CLS_LF)) ||
                     ((brk_ff == BRK_LF) && (cls == CLS_CR));

   // saturating increments
   assign pos_max = (offset_ff == CNT_MAX);
   assign ln_max  = (line_num_ff == CNT_MAX);
   assign ql_max  = (qlen_ff == CNT_MAX);
   assign pos_inc = pos_max ? offset_ff : offset_ff + OFFSET_BITS'(1);
   assign ln_inc  = ln_max ? line_num_ff : line_num_ff + OFFSET_BITS'(1);
   assign ql_inc  = ql_max ? qlen_ff : qlen_ff + OFFSET_BITS'(1);

   // next phase and keyword position
   always_comb begin
      phase_in  = phase_ff;
      kw_idx_in = kw_idx_ff;
      if (cls == CLS_ZERO || (is_break && !pair)) begin
         phase_in  = PH_LINE_BLANKS;
         kw_idx_in = '0;
      end else if (!pair) begin
         case (phase_ff)
            PH_LINE_BLANKS: begin
               if (cls == CLS_HASH) begin
                  phase_in = PH_HASH_BLANKS;
               end else if (cls != CLS_BLANK) begin
                  phase_in = PH_SKIP;
               end
            end
            PH_HASH_BLANKS: begin
               if (cls == CLS_LETTER && head_entry.kw_pos == '0) begin
                  kw_idx_in = KW_IDX_W'(1);
                  phase_in  = PH_KEYWORD;
               end else if (cls != CLS_BLANK) begin
                  phase_in = PH_SKIP;
               end
            end
            PH_KEYWORD: begin
               if (kw_idx_ff < KW_IDX_W'(KW_LEN) && cls == CLS_LETTER &&
                   KW_IDX_W'(head_entry.kw_pos) == kw_idx_ff) begin
                  kw_idx_in = kw_idx_ff + KW_IDX_W'(1);
                  if (kw_idx_ff == KW_IDX_W'(KW_LEN - 1)) begin
                     phase_in = PH_AFTER_WORD;
                  end
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_AFTER_WORD: begin
               phase_in = (cls == CLS_BLANK) ? PH_QUOTE_BLANKS : PH_SKIP;
            end
            PH_QUOTE_BLANKS: begin
               if (cls == CLS_QUOTE) begin
                  phase_in = PH_NAME;
               end else if (cls != CLS_BLANK) begin
                  phase_in = PH_SKIP;
               end
            end
            PH_NAME: begin
               if (cls == CLS_QUOTE) begin
                  phase_in = PH_TAIL;
               end
            end
            PH_TAIL: begin
               phase_in = PH_TAIL;
            end
            default: begin
               phase_in = PH_SKIP;
            end
         endcase
      end
   end

   // counters, break tracking and the record to report
   always_comb begin
      offset_in     = offset_ff;
      line_num_in   = line_num_ff;
      line_start_in = line_start_ff;
      qstart_in     = qstart_ff;
      qlen_in       = qlen_ff;
      brk_in        = BRK_NONE;
      sat_in        = sat_ff;
      emit          = 1'b0;
      rec_found     = 1'b0;
      rec_done      = 1'b0;
      rec_ovf       = sat_ff | ln_max;
      rec_ls        = to_field(line_start_ff);
      rec_le        = to_field(offset_ff);
      rec_ns        = to_field(qstart_ff);
      rec_nl        = to_field(qlen_ff);
      rec_next      = to_field(ln_inc);
      if (cls == CLS_ZERO) begin
         // finish the text and return to the reset state
         emit     = 1'b1;
         rec_done = 1'b1;
         if (phase_ff == PH_TAIL && brk_ff == BRK_NONE) begin
            rec_found = 1'b1;
         end else begin
            rec_ovf  = sat_ff;
            rec_ls   = '0;
            rec_le   = '0;
            rec_ns   = '0;
            rec_nl   = '0;
            rec_next = '0;
         end
         offset_in     = '0;
         line_num_in   = OFFSET_BITS'(1);
         line_start_in = '0;
         qstart_in     = '0;
         qlen_in       = '0;
         sat_in        = 1'b0;
      end else if (pair) begin
         // second half of a two-byte break
         line_start_in = pos_inc;
         offset_in     = pos_inc;
         sat_in        = sat_ff | pos_max;
      end else if (is_break) begin
         emit          = (phase_ff == PH_TAIL);
         rec_found     = 1'b1;
         brk_in        = (cls == CLS_CR) ? BRK_CR : BRK_LF;
         line_num_in   = ln_inc;
         line_start_in = pos_inc;
         offset_in     = pos_inc;
         sat_in        = sat_ff | ln_max | pos_max;
      end else begin
         offset_in = pos_inc;
         sat_in    = sat_ff | pos_max;
         if (phase_ff == PH_QUOTE_BLANKS && cls == CLS_QUOTE) begin
            qstart_in = pos_inc;
            qlen_in   = '0;
         end else if (phase_ff == PH_NAME && cls != CLS_QUOTE) begin
            qlen_in = ql_inc;
            sat_in  = sat_ff | pos_max | ql_max;
         end
      end
   end

   // hold a record until the receiver takes it
   always_comb begin
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LINE_BLANKS;
         kw_idx_ff     <= '0;
         offset_ff     <= '0;
         line_num_ff   <= OFFSET_BITS'(1);
         line_start_ff <= '0;
         qstart_ff     <= '0;
         qlen_ff       <= '0;
         brk_ff        <= BRK_NONE;
         sat_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff      <= phase_in;
            kw_idx_ff     <= kw_idx_in;
            offset_ff     <= offset_in;
            line_num_ff   <= line_num_in;
            line_start_ff <= line_start_in;
            qstart_ff     <= qstart_in;
            qlen_ff       <= qlen_in;
            brk_ff        <= brk_in;
            sat_ff        <= sat_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the result payload
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         found_ff    <= rec_found;
         done_ff     <= rec_done;
         ovf_ff      <= rec_ovf;
         ls_out_ff   <= rec_ls;
         le_out_ff   <= rec_le;
         ns_out_ff   <= rec_ns;
         nl_out_ff   <= rec_nl;
         next_out_ff <= rec_next;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.found          = found_ff;
   assign rsp_chan.done_res       = done_ff;
   assign rsp_chan.overflow       = ovf_ff;
   assign rsp_chan.line_start     = ls_out_ff;
   assign rsp_chan.line_end       = le_out_ff;
   assign rsp_chan.name_start     = ns_out_ff;
   assign rsp_chan.name_length    = nl_out_ff;
   assign rsp_chan.following_line = next_out_ff;

endmodule

@@ sv/include_directive_finder_core.sv @@
// Top level of the include directive finder: front classifier, queue, back scanner.
// Depends on idf_pkg, idf_if, idf_front, idf_queue and idf_back.
//
// Usage:
//   req_chan carries source text, one byte per beat; a zero byte ends the text
//   and returns the scanner to its initial state.
//   rsp_chan carries result records: one when a line holding a complete quoted
//   include directive ends, and one done record for the zero byte.
//   Throughput is one byte per cycle while no stalled receiver holds back a
//   record; a byte is classified and queued in the cycle it is taken.
//   The byte that ends a line passes a queue slot, then the result register,
//   before its record shows on rsp_chan, and waits longer while the queue holds bytes.
//   A stalled receiver holds the record in the result register; the scanner
//   keeps working until the next record is due, then the two-entry queue fills
//   and req_chan.ready drops.
//   Reset (synchronous, active high) empties the queue, drops any pending
//   record and sets offsets to zero and the line number to one.
module include_directive_finder_core (
   input  logic        clock,
   input  logic        reset,
   idf_req_if.sink     req_chan,
   idf_rsp_if.source   rsp_chan
);
   import idf_pkg::*;

   logic       push, pop, q_full, q_not_empty;
   entry_type  push_entry, head_entry;

   idf_front u_front (
      .req_chan   (req_chan),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   idf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   idf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .not_empty  (q_not_empty),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
